@@ sv/mahg_pkg.sv @@
`timescale 1ns / 1ps

package mahg_pkg;

  localparam int SAMPLE_W      = 10;
  localparam int SUM_W         = 16;
  localparam int AVG_SHIFT     = 6;
  localparam int WINDOW_DEPTH_DEF = 64;
  localparam int CFG_IDX_W     = 2;

  localparam logic [SAMPLE_W-1:0] HIGH_THRESHOLD_RST = 10'd563;
  localparam logic [SAMPLE_W-1:0] LOW_THRESHOLD_RST  = 10'd461;

  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_THRESHOLD  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT_OUTPUT  = 2'd2;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [SUM_W-1:0]    sum_t;

endpackage

@@ sv/moving_average_hysteresis_gate_top.sv @@
`timescale 1ns / 1ps

// Box-car average of the last WINDOW_DEPTH samples with a Schmitt-trigger gate. One sample word
// is taken per clock while in_stall is low; its result word passes the s1 register and the
// output register and is taken at an edge while the output is not stalled. The replaced sample
// comes from a one-port-read ring RAM with a registered read, read and written at the same slot
// in the acceptance cycle; the running sum and the gate update as the sample leaves the s1
// register. The ring reads as zero after reset through per-entry valid bits, so no clearing pass
// is needed. The average is always the sum shifted right by six, also for a smaller window. When
// the high threshold is below the low one, "above high" wins. The LED is lit after reset and
// then follows the gate. Thresholds and inversion are written through the cfg port, always
// ready; the user must write them only while the block is idle, which it does not enforce.
module moving_average_hysteresis_gate_top #(
  parameter int WINDOW_DEPTH = mahg_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [mahg_pkg::SAMPLE_W-1:0]  in_sample,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_gate_level,
  output logic                           out_led_on,
  output logic [mahg_pkg::SAMPLE_W-1:0]  out_average,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mahg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mahg_pkg::SAMPLE_W-1:0]  cfg_data
);

  localparam int SLOT_W = $clog2(WINDOW_DEPTH);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_DEPTH - 1);

  mahg_pkg::sample_t       high_threshold_r;
  mahg_pkg::sample_t       low_threshold_r;
  logic                    invert_output_r;

  logic [SLOT_W-1:0]       slot_r;
  logic [WINDOW_DEPTH-1:0] ring_valid_r;
  mahg_pkg::sum_t          sum_r;
  logic                    gate_r;
  logic                    led_r;

  logic                    s1_valid_r;
  mahg_pkg::sample_t       s1_sample_r;
  logic                    s1_old_valid_r;

  logic                    out_valid_r;
  logic                    out_gate_level_r;
  logic                    out_led_on_r;
  mahg_pkg::sample_t       out_average_r;

  logic                    adv;
  logic                    accept;
  logic                    s1_fire;
  mahg_pkg::sample_t       ram_rdata;
  mahg_pkg::sample_t       old_sample;
  mahg_pkg::sum_t          sum_nxt;
  mahg_pkg::sample_t       avg;
  logic                    gate_nxt;
  logic                    led_nxt;

  assign cfg_ready = 1'b1;

  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = s1_valid_r && !adv;
  assign accept   = in_valid && !in_stall;
  assign s1_fire  = s1_valid_r && adv;

  mahg_ram #(
    .WIDTH(mahg_pkg::SAMPLE_W),
    .DEPTH(WINDOW_DEPTH)
  ) u_ring (
    .clk  (clk),
    .we   (accept),
    .waddr(slot_r),
    .wdata(in_sample),
    .re   (accept),
    .raddr(slot_r),
    .rdata(ram_rdata)
  );

  always_comb begin
    old_sample = s1_old_valid_r ? ram_rdata : '0;
    sum_nxt    = sum_r + mahg_pkg::SUM_W'(s1_sample_r) - mahg_pkg::SUM_W'(old_sample);
    avg        = sum_nxt[mahg_pkg::AVG_SHIFT +: mahg_pkg::SAMPLE_W];
    gate_nxt   = gate_r;
    led_nxt    = led_r;
    if (avg > high_threshold_r) begin
      gate_nxt = 1'b1;
      led_nxt  = 1'b1;
    end else if (avg < low_threshold_r) begin
      gate_nxt = 1'b0;
      led_nxt  = 1'b0;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_threshold_r <= mahg_pkg::HIGH_THRESHOLD_RST;
      low_threshold_r  <= mahg_pkg::LOW_THRESHOLD_RST;
      invert_output_r  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mahg_pkg::CFG_HIGH_THRESHOLD: high_threshold_r <= cfg_data;
        mahg_pkg::CFG_LOW_THRESHOLD:  low_threshold_r  <= cfg_data;
        mahg_pkg::CFG_INVERT_OUTPUT:  invert_output_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // acceptance stage: ring slot, valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r       <= '0;
      ring_valid_r <= '0;
      s1_valid_r   <= 1'b0;
    end else begin
      if (accept) begin
        ring_valid_r[slot_r] <= 1'b1;
        slot_r <= (slot_r == SLOT_LAST) ? '0 : slot_r + 1'b1;
        s1_valid_r <= 1'b1;
      end else if (adv) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sample_r    <= in_sample;
      s1_old_valid_r <= ring_valid_r[slot_r];
    end
  end

  // update stage: running sum, gate, output word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      gate_r      <= 1'b0;
      led_r       <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_fire) begin
        sum_r  <= sum_nxt;
        gate_r <= gate_nxt;
        led_r  <= led_nxt;
      end
      if (adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_gate_level_r <= gate_nxt ^ invert_output_r;
      out_led_on_r     <= led_nxt;
      out_average_r    <= avg;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_gate_level = out_gate_level_r;
  assign out_led_on     = out_led_on_r;
  assign out_average    = out_average_r;

endmodule

@@ sv/mahg_ram.sv @@
`timescale 1ns / 1ps

module mahg_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // read-first: a read and a write to the same entry return the old word
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  assign rdata = rdata_r;

endmodule

@@ sv/mahg_chk.sv @@
`timescale 1ns / 1ps

module mahg_chk (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic [mahg_pkg::SAMPLE_W-1:0]  in_sample,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic                           out_gate_level,
  input logic                           out_led_on,
  input logic [mahg_pkg::SAMPLE_W-1:0]  out_average,
  input logic                           cfg_valid,
  input logic                           cfg_ready,
  input logic [mahg_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [mahg_pkg::SAMPLE_W-1:0]  cfg_data
);

  // input only backs up behind a held result word
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while output free");

  // every accepted word is followed by a valid result word behind the s1 and output registers
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> ##1 out_valid)
    else $error("result word missing after accept");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_average)
      && $stable(out_gate_level) && $stable(out_led_on)))
    else $error("stalled result word changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word valid after reset");

endmodule

bind moving_average_hysteresis_gate_top mahg_chk u_mahg_chk (.*);

@@ sim/moving_average_hysteresis_gate_top_tb.sv @@
`timescale 1ns / 1ps

module moving_average_hysteresis_gate_top_tb;

  localparam logic [mahg_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int IDLE_LIMIT = 2000;
  localparam int N_DIRECTED = 25;
  localparam int N_PHASES = 8;
  localparam int WORDS_PER_PHASE = 62;

  typedef struct packed {
    logic              gate_level;
    logic              led_on;
    mahg_pkg::sample_t average;
  } gate_word_t;

  typedef enum logic {ROW_SAMPLE, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e                      kind;
    logic [mahg_pkg::CFG_IDX_W-1:0] idx;
    mahg_pkg::sample_t              value;
    logic                           typed;
    gate_word_t                     word;
  } dir_row_t;

  localparam dir_row_t DIRECTED [N_DIRECTED] = '{
    '{ROW_CFG,    mahg_pkg::CFG_LOW_THRESHOLD,  10'd0,    1'b0, '{1'b0, 1'b0, 10'd0}},
    '{ROW_SAMPLE, '0,                           10'd0,    1'b1, '{1'b0, 1'b1, 10'd0}},
    '{ROW_SAMPLE, '0,                           10'd1023, 1'b1, '{1'b0, 1'b1, 10'd15}},
    '{ROW_SAMPLE, '0,                           10'd1023, 1'b1, '{1'b0, 1'b1, 10'd31}},
    '{ROW_SAMPLE, '0,                           10'h2AA,  1'b0, '0},
    '{ROW_SAMPLE, '0,                           10'h155,  1'b0, '0},
    '{ROW_SAMPLE, '0,                           10'd1,    1'b0, '0},
    '{ROW_SAMPLE, '0,                           10'd512,  1'b0, '0},
    '{ROW_CFG,    mahg_pkg::CFG_HIGH_THRESHOLD, 10'd0,    1'b0, '0},
    '{ROW_CFG,    mahg_pkg::CFG_LOW_THRESHOLD,  10'd1023, 1'b0, '0},
    '{ROW_SAMPLE, '0,                           10'd1023, 1'b0, '0},
    '{ROW_SAMPLE, '0,                           10'd0,    1'b0, '0},
    '{ROW_CFG,    mahg_pkg::CFG_INVERT_OUTPUT,  10'd1,    1'b0, '0},
    '{ROW_SAMPLE, '0,                           10'd0,    1'b0, '0},
    '{ROW_CFG,    CFG_SPARE,                    10'h3FF,  1'b0, '0},
    '{ROW_SAMPLE, '0,                           10'd1023, 1'b0, '0},
    '{ROW_CFG,    mahg_pkg::CFG_HIGH_THRESHOLD, 10'd1023, 1'b0, '0},
    '{ROW_CFG,    mahg_pkg::CFG_LOW_THRESHOLD,  10'd0,    1'b0, '0},
    '{ROW_SAMPLE, '0,                           10'h3FF,  1'b0, '0},
    '{ROW_SAMPLE, '0,                           10'd0,    1'b0, '0},
    '{ROW_CFG,    mahg_pkg::CFG_INVERT_OUTPUT,  10'd0,    1'b0, '0},
    '{ROW_CFG,    mahg_pkg::CFG_HIGH_THRESHOLD, 10'd563,  1'b0, '0},
    '{ROW_CFG,    mahg_pkg::CFG_LOW_THRESHOLD,  10'd461,  1'b0, '0},
    '{ROW_SAMPLE, '0,                           10'd0,    1'b0, '0},
    '{ROW_SAMPLE, '0,                           10'd1023, 1'b0, '0}
  };

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_stall;
  mahg_pkg::sample_t              in_sample;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic                           out_gate_level;
  logic                           out_led_on;
  mahg_pkg::sample_t              out_average;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [mahg_pkg::CFG_IDX_W-1:0] cfg_index;
  mahg_pkg::sample_t              cfg_data;

  moving_average_hysteresis_gate_top u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_sample     (in_sample),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_gate_level(out_gate_level),
    .out_led_on    (out_led_on),
    .out_average   (out_average),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  mahg_pkg::sample_t win_ring [64];
  logic [5:0]        win_slot;
  mahg_pkg::sum_t    win_sum;
  logic              gate_state;
  logic              led_state;
  mahg_pkg::sample_t thr_high;
  mahg_pkg::sample_t thr_low;
  logic              inv_out;

  gate_word_t gate_words_due [$];
  int         mismatch_count = 0;
  int         idle_cycles = 0;

  int burst_left = 0;
  bit sender_steady = 1'b0;

  function automatic gate_word_t next_gate_word(input mahg_pkg::sample_t s);
    gate_word_t        w;
    mahg_pkg::sample_t mean;
    win_sum = win_sum + mahg_pkg::sum_t'(s) - mahg_pkg::sum_t'(win_ring[win_slot]);
    win_ring[win_slot] = s;
    win_slot = win_slot + 1'b1;
    mean = win_sum[mahg_pkg::SUM_W-1:mahg_pkg::AVG_SHIFT];
    if (mean > thr_high) begin
      gate_state = 1'b1;
      led_state = 1'b1;
    end else if (mean < thr_low) begin
      gate_state = 1'b0;
      led_state = 1'b0;
    end
    w.gate_level = gate_state ^ inv_out;
    w.led_on = led_state;
    w.average = mean;
    return w;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  task automatic push_sample(input mahg_pkg::sample_t s, input logic typed,
                             input gate_word_t typed_word);
    gate_word_t w;
    in_valid <= 1'b1;
    in_sample <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    w = next_gate_word(s);
    gate_words_due.push_back(typed ? typed_word : w);
    if (!sender_steady) begin
      if (burst_left == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        burst_left = $urandom_range(1, 40);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic write_reg(input logic [mahg_pkg::CFG_IDX_W-1:0] idx,
                           input mahg_pkg::sample_t value);
    in_valid <= 1'b0;
    while (gate_words_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      mahg_pkg::CFG_HIGH_THRESHOLD: thr_high = value;
      mahg_pkg::CFG_LOW_THRESHOLD:  thr_low = value;
      mahg_pkg::CFG_INVERT_OUTPUT:  inv_out = value[0];
      default: ;
    endcase
  endtask

  // receiver stall pattern: open runs, solid stalls, and coin-flip stretches
  int stall_mode = 0;
  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = (stall_mode == 1) ? $urandom_range(1, 12) : $urandom_range(1, 40);
    end
    stall_left--;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= 1'b1;
      default: out_stall <= 1'($urandom_range(0, 1));
    endcase
  end

  always @(posedge clk) begin
    gate_word_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (gate_words_due.size() == 0) begin
        report_mismatch("word with none due, average", int'(out_average), -1);
      end else begin
        w = gate_words_due.pop_front();
        if (out_gate_level !== w.gate_level)
          report_mismatch("gate_level", int'(out_gate_level), int'(w.gate_level));
        if (out_led_on !== w.led_on)
          report_mismatch("led_on", int'(out_led_on), int'(w.led_on));
        if (out_average !== w.average)
          report_mismatch("average", int'(out_average), int'(w.average));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int                v;
    int                level;
    int                amp;
    int                run_left;
    bit                noisy_run;
    mahg_pkg::sample_t hi;
    mahg_pkg::sample_t lo;
    logic              inv;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_sample = '0;
    cfg_valid = 1'b0;
    cfg_index = mahg_pkg::CFG_HIGH_THRESHOLD;
    cfg_data = '0;
    for (int i = 0; i < 64; i++) win_ring[i] = '0;
    win_slot = '0;
    win_sum = '0;
    gate_state = 1'b0;
    led_state = 1'b1;
    thr_high = mahg_pkg::HIGH_THRESHOLD_RST;
    thr_low = mahg_pkg::LOW_THRESHOLD_RST;
    inv_out = 1'b0;
    burst_left = $urandom_range(1, 20);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < N_DIRECTED; r++) begin
      if (DIRECTED[r].kind == ROW_CFG)
        write_reg(DIRECTED[r].idx, DIRECTED[r].value);
      else
        push_sample(DIRECTED[r].value, DIRECTED[r].typed, DIRECTED[r].word);
    end

    // first run fills the window with full scale to reach the top average
    run_left = 80;
    level = 1023;
    amp = 0;
    noisy_run = 1'b0;
    for (int phase = 0; phase < N_PHASES; phase++) begin
      case (phase)
        0: begin
          hi = mahg_pkg::HIGH_THRESHOLD_RST;
          lo = mahg_pkg::LOW_THRESHOLD_RST;
          inv = 1'b0;
        end
        1: begin hi = 10'd1023; lo = 10'd0; inv = 1'b1; end
        2: begin hi = 10'd0; lo = 10'd1023; inv = 1'b0; end
        3: begin hi = 10'd0; lo = 10'd0; inv = 1'b1; end
        4: begin
          lo = mahg_pkg::sample_t'($urandom_range(0, 900));
          hi = lo + mahg_pkg::sample_t'($urandom_range(1, 123));
          inv = 1'($urandom_range(0, 1));
        end
        5: begin
          hi = mahg_pkg::sample_t'($urandom_range(0, 900));
          lo = hi + mahg_pkg::sample_t'($urandom_range(1, 123));
          inv = 1'($urandom_range(0, 1));
        end
        6: begin hi = 10'd1023; lo = 10'd1023; inv = 1'b0; end
        default: begin
          hi = mahg_pkg::sample_t'($urandom_range(0, 1023));
          lo = mahg_pkg::sample_t'($urandom_range(0, 1023));
          inv = 1'($urandom_range(0, 1));
        end
      endcase
      write_reg(mahg_pkg::CFG_HIGH_THRESHOLD, hi);
      write_reg(mahg_pkg::CFG_LOW_THRESHOLD, lo);
      write_reg(mahg_pkg::CFG_INVERT_OUTPUT, mahg_pkg::sample_t'(inv));
      if (phase == N_PHASES - 1)
        write_reg(CFG_SPARE, mahg_pkg::sample_t'($urandom_range(0, 1023)));
      sender_steady = (phase % 3 == 1);
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        if (run_left == 0) begin
          run_left = $urandom_range(8, 90);
          noisy_run = ($urandom_range(0, 6) == 0);
          case ($urandom_range(0, 3))
            0: level = 0;
            1: level = 1023;
            default: level = $urandom_range(0, 1023);
          endcase
          amp = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 64);
        end
        run_left--;
        if (noisy_run) begin
          v = $urandom_range(0, 1023);
        end else begin
          v = level + int'($urandom_range(0, 2 * amp)) - amp;
          if (v < 0) v = 0;
          else if (v > 1023) v = 1023;
        end
        push_sample(mahg_pkg::sample_t'(v), 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (gate_words_due.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    if (mismatch_count == 0 && gate_words_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/mahg_pkg.sv
sv/mahg_ram.sv
sv/moving_average_hysteresis_gate_top.sv
sv/mahg_chk.sv
sim/moving_average_hysteresis_gate_top_tb.sv
